/* rtl/rsi_pkg.sv */
// package for the ray / sphere intersection unit
// default coordinate format, normal format and configuration register indexes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NORM_FRAC  = 14;
  localparam int NORM_W     = 16;
  localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1) << NORM_FRAC;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd3;

endpackage

`default_nettype wire

/* rtl/ray_sphere_intersect_unit.sv */
// ray / sphere intersection unit: nearest positive root, hit point normal
// depends on rsi_pkg for default formats and register indexes
// pipeline built around the bit-per-stage square root, distance divide, second square root
// and normal divide chains
// throughput: one item per cycle, busy stays low, the receiver cannot stall
// reset: synchronous active low, clears valid bits, centre to zero, radius to one
`timescale 1ns / 1ps
`default_nettype none

module ray_sphere_intersect_unit #(
  parameter int COORD_BITS = rsi_pkg::COORD_BITS,
  parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [COORD_BITS-1:0]         in_origin_x,
  input  wire logic signed [COORD_BITS-1:0]         in_origin_y,
  input  wire logic signed [COORD_BITS-1:0]         in_origin_z,
  input  wire logic signed [COORD_BITS-1:0]         in_dir_x,
  input  wire logic signed [COORD_BITS-1:0]         in_dir_y,
  input  wire logic signed [COORD_BITS-1:0]         in_dir_z,
  output logic                                      out_strobe,
  output logic                                      out_hit,
  output logic [COORD_BITS-2:0]                     out_distance,
  output logic signed [rsi_pkg::NORM_W-1:0]         out_normal_x,
  output logic signed [rsi_pkg::NORM_W-1:0]         out_normal_y,
  output logic signed [rsi_pkg::NORM_W-1:0]         out_normal_z,
  input  wire logic                                 cfg_we,
  input  wire logic [rsi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [COORD_BITS-1:0]                cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int FB   = FRAC_BITS;
  localparam int NF   = rsi_pkg::NORM_FRAC;
  localparam int OW   = rsi_pkg::NORM_W;
  localparam int EW   = CB + 1;
  localparam int PW   = 2 * CB + 2;
  localparam int AW   = 2 * CB;
  localparam int BW   = PW;
  localparam int CW   = 2 * CB + 3;
  localparam int BMW  = 2 * CB + 1;
  localparam int CMW  = 2 * CB + 2;
  localparam int HW   = CB + 1;
  localparam int XW   = 4 * CB + 4;
  localparam int SW   = XW / 2;
  localparam int NUMW = 2 * CB + 4;
  localparam int UMW  = 2 * CB + 2;
  localparam int RW   = ((UMW + FB > AW + CB - 1) ? UMW + FB : AW + CB - 1) + 1;
  localparam int TW   = CB - 1;
  localparam int NW   = ((CB + 1 + FB > 2 * CB) ? CB + 1 + FB : 2 * CB) + 1;
  localparam int NMW  = NW - 1;
  localparam int H2   = (NMW + 1) / 2;
  localparam int H2L  = NMW - H2;
  localparam int Q2W  = 2 * NMW + 2;
  localparam int MW   = Q2W / 2;
  localparam int NQ   = NF + 2;
  localparam int RW2  = MW + NQ;

  typedef struct packed {
    logic                     miss;
    logic [2:0][EW-1:0]       e;
    logic [2:0][CB-1:0]       d;
    logic [AW-1:0]            a;
    logic [BW-1:0]            b;
    logic [TW-1:0]            tdist;
    logic [2:0][NMW-1:0]      nm;
    logic [2:0]               nneg;
    logic [MW-1:0]            m;
  } side_t;

  // configuration registers
  logic signed [CB-1:0] ctr_r [3];
  logic [CB-2:0]        rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r[0] <= '0;
      ctr_r[1] <= '0;
      ctr_r[2] <= '0;
      rad_r    <= (CB-1)'(1) << FB;
    end else if (cfg_we) begin
      case (cfg_index)
        rsi_pkg::REG_CENTER_X: ctr_r[0] <= cfg_data;
        rsi_pkg::REG_CENTER_Y: ctr_r[1] <= cfg_data;
        rsi_pkg::REG_CENTER_Z: ctr_r[2] <= cfg_data;
        rsi_pkg::REG_RADIUS:   rad_r    <= cfg_data[CB-2:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic signed [CB-1:0] org [3];
  logic signed [CB-1:0] dir [3];
  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;
  assign dir[0] = in_dir_x;
  assign dir[1] = in_dir_y;
  assign dir[2] = in_dir_z;

  // stage 1: offset from centre
  logic  v1_r;
  side_t sd1_r, sd1_nxt;

  always_comb begin
    sd1_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      sd1_nxt.e[k] = EW'(org[k]) - EW'(ctr_r[k]);
      sd1_nxt.d[k] = dir[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start & ~busy;
    sd1_r <= sd1_nxt;
  end

  // stage 2: dot product terms
  logic              v2_r;
  side_t             sd2_r;
  logic signed [PW-1:0] pdd2_r [3];
  logic signed [PW-1:0] pde2_r [3];
  logic signed [PW-1:0] pee2_r [3];
  logic [2*CB-3:0]   rr2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    sd2_r <= sd1_r;
    for (int k = 0; k < 3; k++) begin
      pdd2_r[k] <= PW'($signed(sd1_r.d[k]) * $signed(sd1_r.d[k]));
      pde2_r[k] <= PW'($signed(sd1_r.d[k]) * $signed(sd1_r.e[k]));
      pee2_r[k] <= PW'($signed(sd1_r.e[k]) * $signed(sd1_r.e[k]));
    end
    rr2_r <= rad_r * rad_r;
  end

  // stage 3: quadratic coefficients
  logic                 v3_r;
  side_t                sd3_r, sd3_nxt;
  logic signed [CW-1:0] c3_r, c3_nxt;
  logic signed [PW-1:0] asum, bsum;

  always_comb begin
    asum = pdd2_r[0] + pdd2_r[1] + pdd2_r[2];
    bsum = pde2_r[0] + pde2_r[1] + pde2_r[2];
    c3_nxt = CW'(pee2_r[0]) + CW'(pee2_r[1]) + CW'(pee2_r[2]) - CW'(rr2_r);
    sd3_nxt = sd2_r;
    sd3_nxt.a = asum[AW-1:0];
    sd3_nxt.b = bsum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    sd3_r <= sd3_nxt;
    c3_r  <= c3_nxt;
  end

  // stage 4: partial products of b*b and a*c
  logic                 v4_r;
  side_t                sd4_r, sd4_nxt;
  logic [BMW-1:0]       bmag;
  logic [CMW-1:0]       cmag;
  logic [2*HW-1:0]      bll4_r;
  logic [CB+HW-1:0]     bhl4_r;
  logic [2*CB-1:0]      bhh4_r;
  logic [2*HW-1:0]      all4_r;
  logic [2*CB-1:0]      ahl4_r;
  logic [2*CB+1:0]      alh4_r;
  logic [2*CB-1:0]      ahh4_r;
  logic                 cneg4_r;

  always_comb begin
    bmag = sd3_r.b[BW-1] ? BMW'(-$signed(sd3_r.b)) : BMW'(sd3_r.b);
    cmag = c3_r[CW-1] ? CMW'(-c3_r) : CMW'(c3_r);
    sd4_nxt = sd3_r;
    sd4_nxt.miss = (sd3_r.a == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    sd4_r   <= sd4_nxt;
    bll4_r  <= bmag[HW-1:0] * bmag[HW-1:0];
    bhl4_r  <= bmag[BMW-1:HW] * bmag[HW-1:0];
    bhh4_r  <= bmag[BMW-1:HW] * bmag[BMW-1:HW];
    all4_r  <= sd3_r.a[HW-1:0] * cmag[HW-1:0];
    ahl4_r  <= sd3_r.a[AW-1:HW] * cmag[HW-1:0];
    alh4_r  <= sd3_r.a[HW-1:0] * cmag[CMW-1:HW];
    ahh4_r  <= sd3_r.a[AW-1:HW] * cmag[CMW-1:HW];
    cneg4_r <= c3_r[CW-1];
  end

  // stage 5: full products
  logic          v5_r;
  side_t         sd5_r;
  logic [XW-1:0] bb5_r, ac5_r;
  logic          cneg5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
    sd5_r   <= sd4_r;
    bb5_r   <= (XW'(bhh4_r) << (2 * HW)) + (XW'(bhl4_r) << (HW + 1)) + XW'(bll4_r);
    ac5_r   <= (XW'(ahh4_r) << (2 * HW)) + ((XW'(ahl4_r) + XW'(alh4_r)) << HW)
               + XW'(all4_r);
    cneg5_r <= cneg4_r;
  end

  // stage 6 and square root chain of the discriminant
  logic [SW:0]   sq_v_r;
  side_t         sq_sd_r  [SW+1];
  logic [XW-1:0] sq_x_r   [SW+1];
  logic [XW-1:0] sq_res_r [SW+1];
  side_t         sd6_nxt;
  logic [XW-1:0] disc6;

  always_comb begin
    sd6_nxt = sd5_r;
    disc6   = '0;
    if (cneg5_r) begin
      disc6 = bb5_r + ac5_r;
    end else if (bb5_r >= ac5_r) begin
      disc6 = bb5_r - ac5_r;
    end else begin
      sd6_nxt.miss = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else        sq_v_r[0] <= v5_r;
    sq_sd_r[0]  <= sd6_nxt;
    sq_x_r[0]   <= disc6;
    sq_res_r[0] <= '0;
  end

  for (genvar j = 0; j < SW; j++) begin : g_sqrt1
    localparam int K = SW - 1 - j;
    localparam logic [XW-1:0] ONEBIT = XW'(1) << (2 * K);
    logic [XW-1:0] trial;
    assign trial = sq_res_r[j] + ONEBIT;
    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[j+1] <= 1'b0;
      else        sq_v_r[j+1] <= sq_v_r[j];
      sq_sd_r[j+1] <= sq_sd_r[j];
      if (sq_x_r[j] >= trial) begin
        sq_x_r[j+1]   <= sq_x_r[j] - trial;
        sq_res_r[j+1] <= (sq_res_r[j] >> 1) + ONEBIT;
      end else begin
        sq_x_r[j+1]   <= sq_x_r[j];
        sq_res_r[j+1] <= sq_res_r[j] >> 1;
      end
    end
  end

  // candidate numerators
  logic                   vc_r;
  side_t                  sdc_r;
  logic signed [NUMW-1:0] c0c_r, c1c_r;
  logic [SW-1:0]          sroot;

  assign sroot = sq_res_r[SW][SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else        vc_r <= sq_v_r[SW];
    sdc_r <= sq_sd_r[SW];
    c0c_r <= -NUMW'($signed(sq_sd_r[SW].b)) - NUMW'(sroot);
    c1c_r <= -NUMW'($signed(sq_sd_r[SW].b)) + NUMW'(sroot);
  end

  // root choice: smallest candidate whose distance is at least one lsb
  logic           vs_r;
  side_t          sds_r, sds_nxt;
  logic [UMW-1:0] num_r, num_nxt;
  logic [RW-1:0]  sh0, sh1;
  logic           ok0, ok1;

  always_comb begin
    sh0 = RW'({c0c_r[UMW-1:0], {FB{1'b0}}});
    sh1 = RW'({c1c_r[UMW-1:0], {FB{1'b0}}});
    ok0 = !c0c_r[NUMW-1] && (c0c_r != '0) && (sh0 >= RW'(sdc_r.a));
    ok1 = !c1c_r[NUMW-1] && (c1c_r != '0) && (sh1 >= RW'(sdc_r.a));
    num_nxt = ok0 ? c0c_r[UMW-1:0] : c1c_r[UMW-1:0];
    sds_nxt = sdc_r;
    sds_nxt.miss = sdc_r.miss | ~(ok0 | ok1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vs_r <= 1'b0;
    else        vs_r <= vc_r;
    sds_r <= sds_nxt;
    num_r <= num_nxt;
  end

  // range check and distance divide chain
  logic [TW:0]   dv_v_r;
  side_t         dv_sd_r  [TW+1];
  logic [RW-1:0] dv_rem_r [TW+1];
  side_t         sdo_nxt;
  logic [RW-1:0] rem0;

  always_comb begin
    rem0 = RW'({num_r, {FB{1'b0}}});
    sdo_nxt = sds_r;
    sdo_nxt.tdist = '0;
    if (rem0 >= (RW'(sds_r.a) << (CB - 1))) sdo_nxt.miss = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else        dv_v_r[0] <= vs_r;
    dv_sd_r[0]  <= sdo_nxt;
    dv_rem_r[0] <= rem0;
  end

  for (genvar j = 0; j < TW; j++) begin : g_div1
    localparam int K = TW - 1 - j;
    logic [RW-1:0] sub;
    side_t         nx;
    assign sub = RW'(dv_sd_r[j].a) << K;
    always_comb begin
      nx = dv_sd_r[j];
      nx.tdist[K] = (dv_rem_r[j] >= sub);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j+1] <= 1'b0;
      else        dv_v_r[j+1] <= dv_v_r[j];
      dv_sd_r[j+1]  <= nx;
      dv_rem_r[j+1] <= (dv_rem_r[j] >= sub) ? dv_rem_r[j] - sub : dv_rem_r[j];
    end
  end

  // hit point relative to the centre
  logic                 vp_r;
  side_t                sdp_r;
  logic signed [NW-1:0] prp_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else        vp_r <= dv_v_r[TW];
    sdp_r <= dv_sd_r[TW];
    for (int k = 0; k < 3; k++) begin
      prp_r[k] <= NW'($signed(dv_sd_r[TW].d[k]) * $signed({1'b0, dv_sd_r[TW].tdist}));
    end
  end

  logic                 vn_r;
  side_t                sdn_r, sdn_nxt;
  logic signed [NW-1:0] nvec [3];

  always_comb begin
    sdn_nxt = sdp_r;
    for (int k = 0; k < 3; k++) begin
      nvec[k] = (NW'($signed(sdp_r.e[k])) <<< FB) + prp_r[k];
      sdn_nxt.nneg[k] = nvec[k][NW-1];
      sdn_nxt.nm[k]   = nvec[k][NW-1] ? NMW'(-nvec[k]) : NMW'(nvec[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vn_r <= 1'b0;
    else        vn_r <= vp_r;
    sdn_r <= sdn_nxt;
  end

  // squared length of the hit point vector
  logic              vq_r;
  side_t             sdq_r;
  logic [2*H2-1:0]   nll_r [3];
  logic [H2L+H2-1:0] nhl_r [3];
  logic [2*H2L-1:0]  nhh_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) vq_r <= 1'b0;
    else        vq_r <= vn_r;
    sdq_r <= sdn_r;
    for (int k = 0; k < 3; k++) begin
      nll_r[k] <= sdn_r.nm[k][H2-1:0] * sdn_r.nm[k][H2-1:0];
      nhl_r[k] <= sdn_r.nm[k][NMW-1:H2] * sdn_r.nm[k][H2-1:0];
      nhh_r[k] <= sdn_r.nm[k][NMW-1:H2] * sdn_r.nm[k][NMW-1:H2];
    end
  end

  logic           vr_r;
  side_t          sdr_r;
  logic [Q2W-1:0] sqr_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) vr_r <= 1'b0;
    else        vr_r <= vq_r;
    sdr_r <= sdq_r;
    for (int k = 0; k < 3; k++) begin
      sqr_r[k] <= (Q2W'(nhh_r[k]) << (2 * H2)) + (Q2W'(nhl_r[k]) << (H2 + 1))
                  + Q2W'(nll_r[k]);
    end
  end

  // square root chain of the length
  logic [MW:0]    sr_v_r;
  side_t          sr_sd_r  [MW+1];
  logic [Q2W-1:0] sr_x_r   [MW+1];
  logic [Q2W-1:0] sr_res_r [MW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sr_v_r[0] <= 1'b0;
    else        sr_v_r[0] <= vr_r;
    sr_sd_r[0]  <= sdr_r;
    sr_x_r[0]   <= sqr_r[0] + sqr_r[1] + sqr_r[2];
    sr_res_r[0] <= '0;
  end

  for (genvar j = 0; j < MW; j++) begin : g_sqrt2
    localparam int K = MW - 1 - j;
    localparam logic [Q2W-1:0] ONEBIT = Q2W'(1) << (2 * K);
    logic [Q2W-1:0] trial;
    assign trial = sr_res_r[j] + ONEBIT;
    always_ff @(posedge clk) begin
      if (!rst_n) sr_v_r[j+1] <= 1'b0;
      else        sr_v_r[j+1] <= sr_v_r[j];
      sr_sd_r[j+1] <= sr_sd_r[j];
      if (sr_x_r[j] >= trial) begin
        sr_x_r[j+1]   <= sr_x_r[j] - trial;
        sr_res_r[j+1] <= (sr_res_r[j] >> 1) + ONEBIT;
      end else begin
        sr_x_r[j+1]   <= sr_x_r[j];
        sr_res_r[j+1] <= sr_res_r[j] >> 1;
      end
    end
  end

  // normal divide chains, one per axis
  logic [NQ:0]    nd_v_r;
  side_t          nd_sd_r  [NQ+1];
  logic [RW2-1:0] nd_rem_r [NQ+1][3];
  logic [NQ-1:0]  nd_q_r   [NQ+1][3];
  side_t          sdm_nxt;

  always_comb begin
    sdm_nxt = sr_sd_r[MW];
    sdm_nxt.m = sr_res_r[MW][MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) nd_v_r[0] <= 1'b0;
    else        nd_v_r[0] <= sr_v_r[MW];
    nd_sd_r[0] <= sdm_nxt;
    for (int k = 0; k < 3; k++) begin
      nd_rem_r[0][k] <= RW2'({sr_sd_r[MW].nm[k], {(NF + 1){1'b0}}});
      nd_q_r[0][k]   <= '0;
    end
  end

  for (genvar j = 0; j < NQ; j++) begin : g_div2
    localparam int K = NQ - 1 - j;
    localparam logic [NQ-1:0] QBIT = NQ'(1) << K;
    logic [RW2-1:0] sub;
    assign sub = RW2'(nd_sd_r[j].m) << K;
    always_ff @(posedge clk) begin
      if (!rst_n) nd_v_r[j+1] <= 1'b0;
      else        nd_v_r[j+1] <= nd_v_r[j];
      nd_sd_r[j+1] <= nd_sd_r[j];
      for (int k = 0; k < 3; k++) begin
        if (nd_rem_r[j][k] >= sub) begin
          nd_rem_r[j+1][k] <= nd_rem_r[j][k] - sub;
          nd_q_r[j+1][k]   <= nd_q_r[j][k] | QBIT;
        end else begin
          nd_rem_r[j+1][k] <= nd_rem_r[j][k];
          nd_q_r[j+1][k]   <= nd_q_r[j][k];
        end
      end
    end
  end

  // rounding, limit, sign and result register
  logic                 out_strobe_r, out_hit_r;
  logic [TW-1:0]        out_distance_r;
  logic signed [OW-1:0] out_normal_r [3];
  logic signed [OW-1:0] nrm_nxt [3];
  logic [NQ:0]          rnd [3];
  logic [OW-1:0]        mag [3];
  side_t                sdf;

  always_comb begin
    sdf = nd_sd_r[NQ];
    for (int k = 0; k < 3; k++) begin
      rnd[k] = ({1'b0, nd_q_r[NQ][k]} + (NQ+1)'(1)) >> 1;
      mag[k] = (rnd[k] > (NQ+1)'(rsi_pkg::NORM_ONE)) ? rsi_pkg::NORM_ONE : OW'(rnd[k]);
      if (sdf.miss || (sdf.m == '0)) mag[k] = '0;
      nrm_nxt[k] = sdf.nneg[k] ? -$signed(mag[k]) : $signed(mag[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= nd_v_r[NQ];
    out_hit_r      <= ~sdf.miss;
    out_distance_r <= sdf.miss ? '0 : sdf.tdist;
    for (int k = 0; k < 3; k++) out_normal_r[k] <= nrm_nxt[k];
  end

  assign out_strobe   = out_strobe_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_distance_r;
  assign out_normal_x = out_normal_r[0];
  assign out_normal_y = out_normal_r[1];
  assign out_normal_z = out_normal_r[2];

endmodule

`default_nettype wire

/* test/ray_sphere_intersect_unit_checker.sv */
// checker for the ray / sphere intersection unit: tracks the register writes,
// predicts each result from the accepted rays and compares in order
// depends on rsi_pkg for formats and register indexes
`timescale 1ns / 1ps

module ray_sphere_intersect_unit_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic signed [rsi_pkg::COORD_BITS-1:0]  in_origin_x,
  input  logic signed [rsi_pkg::COORD_BITS-1:0]  in_origin_y,
  input  logic signed [rsi_pkg::COORD_BITS-1:0]  in_origin_z,
  input  logic signed [rsi_pkg::COORD_BITS-1:0]  in_dir_x,
  input  logic signed [rsi_pkg::COORD_BITS-1:0]  in_dir_y,
  input  logic signed [rsi_pkg::COORD_BITS-1:0]  in_dir_z,
  input  logic                                   out_strobe,
  input  logic                                   out_hit,
  input  logic [rsi_pkg::COORD_BITS-2:0]         out_distance,
  input  logic signed [rsi_pkg::NORM_W-1:0]      out_normal_x,
  input  logic signed [rsi_pkg::NORM_W-1:0]      out_normal_y,
  input  logic signed [rsi_pkg::NORM_W-1:0]      out_normal_z,
  input  logic                                   cfg_we,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [rsi_pkg::COORD_BITS-1:0]         cfg_data,
  output int                                     pending,
  output int                                     failures
);
  import rsi_pkg::*;

  typedef logic signed [319:0] wide_t;
  typedef logic [319:0] uwide_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                     hit;
    logic [COORD_BITS-2:0]    distance;
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
  } hit_record_t;

  coord_t centre [3];
  logic [COORD_BITS-2:0] radius;
  hit_record_t expected_hits [$];

  function automatic wide_t floor_sqrt(uwide_t n);
    uwide_t r, c;
    r = '0;
    for (int i = 159; i >= 0; i--) begin
      c = r | (uwide_t'(1) << i);
      if (c * c <= n) r = c;
    end
    return wide_t'(r);
  endfunction

  function automatic hit_record_t trace_ray(coord_t org [3], coord_t dir [3]);
    hit_record_t res;
    wide_t e [3], d [3], n [3];
    wide_t a, b, c, disc, s, cand, t, tdist, q2, m, mag, v;
    logic found;
    res = '0;
    found = 1'b0;
    tdist = 0;
    a = 0; b = 0; c = 0;
    for (int k = 0; k < 3; k++) begin
      e[k] = wide_t'(org[k]) - wide_t'(centre[k]);
      d[k] = wide_t'(dir[k]);
      a = a + d[k] * d[k];
      b = b + d[k] * e[k];
      c = c + e[k] * e[k];
    end
    c = c - wide_t'({1'b0, radius}) * wide_t'({1'b0, radius});
    if (a == 0) return res;
    disc = b * b - a * c;
    if (disc < 0) return res;
    s = floor_sqrt(uwide_t'(disc));
    for (int k = 0; k < 2; k++) begin
      if (!found) begin
        cand = (k == 0) ? -b - s : -b + s;
        if (cand > 0) begin
          t = (cand <<< FRAC_BITS) / a;
          if (t != 0) begin
            if (t > ((wide_t'(1) <<< (COORD_BITS - 1)) - 1)) return res;
            tdist = t;
            found = 1'b1;
          end
        end
      end
    end
    if (!found) return res;
    res.hit = 1'b1;
    res.distance = tdist[COORD_BITS-2:0];
    q2 = 0;
    for (int k = 0; k < 3; k++) begin
      n[k] = e[k] * (wide_t'(1) <<< FRAC_BITS) + d[k] * tdist;
      q2 = q2 + n[k] * n[k];
    end
    m = floor_sqrt(uwide_t'(q2));
    for (int k = 0; k < 3; k++) begin
      v = 0;
      if (m != 0) begin
        mag = (n[k] < 0) ? -n[k] : n[k];
        v = (((mag <<< (NORM_FRAC + 1)) / m) + 1) >>> 1;
        if (v > wide_t'(NORM_ONE)) v = wide_t'(NORM_ONE);
      end
      if (n[k] < 0) v = -v;
      case (k)
        0: res.nx = v[NORM_W-1:0];
        1: res.ny = v[NORM_W-1:0];
        default: res.nz = v[NORM_W-1:0];
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    coord_t org [3], dir [3];
    hit_record_t exp_rec, got;
    if (!rst_n) begin
      centre[0] = '0; centre[1] = '0; centre[2] = '0;
      radius = (COORD_BITS-1)'(1) << FRAC_BITS;
      expected_hits.delete();
      failures = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER_X: centre[0] = cfg_data;
          REG_CENTER_Y: centre[1] = cfg_data;
          REG_CENTER_Z: centre[2] = cfg_data;
          REG_RADIUS:   radius = cfg_data[COORD_BITS-2:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        org[0] = in_origin_x; org[1] = in_origin_y; org[2] = in_origin_z;
        dir[0] = in_dir_x; dir[1] = in_dir_y; dir[2] = in_dir_z;
        expected_hits.push_back(trace_ray(org, dir));
      end
      if (out_strobe) begin
        got = '{out_hit, out_distance, out_normal_x, out_normal_y, out_normal_z};
        if (expected_hits.size() == 0) begin
          failures++;
          if (failures <= 10) $display("unexpected result %h", got);
        end else begin
          exp_rec = expected_hits.pop_front();
          if (got !== exp_rec) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: hit %b/%b dist %h/%h normal %h %h %h / %h %h %h",
                       exp_rec.hit, got.hit, exp_rec.distance, got.distance,
                       exp_rec.nx, exp_rec.ny, exp_rec.nz, got.nx, got.ny, got.nz);
          end
        end
      end
    end
    pending = expected_hits.size();
  end

endmodule

/* test/ray_sphere_intersect_unit_tb.sv */
// top of the ray / sphere intersection unit regression: clock, reset, rays,
// register phases and the verdict
// depends on rsi_pkg, ray_sphere_intersect_unit and ray_sphere_intersect_unit_checker
`timescale 1ns / 1ps

module ray_sphere_intersect_unit_tb;
  import rsi_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  coord_t in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_strobe, out_hit;
  logic [COORD_BITS-2:0] out_distance;
  logic signed [NORM_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CENTER_X;
  logic [COORD_BITS-1:0] cfg_data = '0;
  int pending, failures;
  int cycles = 0;
  coord_t sph_c [3];

  localparam int LATENCY = 194;
  localparam int CYCLE_LIMIT = 300000;
  localparam coord_t ONE = coord_t'(1) <<< FRAC_BITS;
  localparam coord_t MAXC = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t MINC = {1'b1, {(COORD_BITS-1){1'b0}}};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ray_sphere_intersect_unit dut (.*);
  ray_sphere_intersect_unit_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_sphere_intersect_unit regression: fail");
      $finish;
    end
  end

  task automatic send_ray(coord_t ox, coord_t oy, coord_t oz,
                          coord_t dx, coord_t dy, coord_t dz);
    in_origin_x <= ox; in_origin_y <= oy; in_origin_z <= oz;
    in_dir_x <= dx; in_dir_y <= dy; in_dir_z <= dz;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sphere(coord_t cx, coord_t cy, coord_t cz, logic [COORD_BITS-1:0] r);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, r);
    sph_c[0] = cx; sph_c[1] = cy; sph_c[2] = cz;
  endtask

  function automatic coord_t rand_coord(int mode);
    coord_t v;
    v = $urandom;
    case (mode)
      0: v = v >>> $urandom_range(31, 8);
      1: v = v >>> $urandom_range(16, 4);
      default: ;
    endcase
    return v;
  endfunction

  // mostly rays near the sphere, aimed at it or away, then small random rays and arbitrary bit patterns
  task automatic random_rays(int count);
    coord_t o [3], d [3];
    int sent, burst, mode;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(40, 1);
      for (int i = 0; i < burst && sent < count; i++) begin
        mode = $urandom_range(9);
        for (int k = 0; k < 3; k++) begin
          if (mode < 6) begin
            o[k] = sph_c[k] + rand_coord(0);
            d[k] = sph_c[k] - o[k] + rand_coord(0);
            if (mode == 5) d[k] = -d[k];
          end else if (mode < 8) begin
            o[k] = rand_coord(1);
            d[k] = rand_coord(1);
          end else begin
            o[k] = rand_coord(2);
            d[k] = rand_coord(2);
          end
        end
        send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
        sent++;
      end
      if ($urandom_range(3) != 0) pause($urandom_range(12, 1));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    sph_c[0] = '0; sph_c[1] = '0; sph_c[2] = '0;

    // directed rays against the unit sphere at the origin
    send_ray(-4 * ONE, 0, 0, ONE, 0, 0);
    send_ray(0, 0, 0, 0, ONE, 0);
    send_ray(0, 0, 4 * ONE, 0, 0, ONE);
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(-4 * ONE, 2 * ONE, 0, ONE, 0, 0);
    send_ray(-4 * ONE, ONE, 0, ONE, 0, 0);
    send_ray(-4 * ONE, 0, 0, 1, 0, 0);
    send_ray(MINC, MINC, MINC, MAXC, MAXC, MAXC);
    send_ray(MAXC, MAXC, MAXC, MINC, MINC, MINC);
    send_ray(MINC, 0, 0, MAXC, 0, 0);
    send_ray(ONE, 0, 0, -ONE, 0, 0);
    pause(3);
    send_ray(-3 * ONE, -3 * ONE, -3 * ONE, ONE, ONE, ONE);
    send_ray(0, -ONE / 2, 0, MINC, 0, 1);
    drain();

    // zero radius gives a degenerate normal, then extremes of the registers
    set_sphere(5 * ONE, 0, 0, 0);
    send_ray(0, 0, 0, ONE, 0, 0);
    send_ray(0, 0, 0, 0, ONE, 0);
    random_rays(60);
    drain();
    set_sphere(0, 0, 0, {1'b0, {(COORD_BITS-1){1'b1}}});
    send_ray(0, 0, 0, ONE, ONE, 0);
    send_ray(MAXC, MAXC, MAXC, MAXC, 0, 0);
    random_rays(150);
    drain();
    set_sphere(MAXC, MINC, MAXC, 1000 * ONE);
    send_ray(0, 0, 0, MAXC, MINC, MAXC);
    random_rays(200);
    drain();
    set_sphere(MINC, MAXC, MINC, 3);
    random_rays(150);
    drain();
    for (int p = 0; p < 5; p++) begin
      set_sphere(rand_coord(0), rand_coord(0), rand_coord(0),
                 COORD_BITS'({1'b0, $urandom} >> $urandom_range(31, 10)));
      random_rays(150);
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("ray_sphere_intersect_unit regression: pass");
    end else begin
      $display("ray_sphere_intersect_unit regression: fail");
    end
    $finish;
  end

endmodule
